// ===== rtl/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_DATA = 2'd0;
    localparam t_status ST_TERM = 2'd1;
    localparam t_status ST_BAD  = 2'd2;
    localparam t_status ST_FULL = 2'd3;

    // lead byte ranges and second byte bounds
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD3_SUR = 8'hED;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] E0_LO     = 8'hA0;
    localparam logic [7:0] ED_HI     = 8'h9F;
    localparam logic [7:0] F0_LO     = 8'h90;
    localparam logic [7:0] F4_HI     = 8'h8F;

    // supplementary plane split
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [15:0] HI_SURR   = 16'hD800;
    localparam logic [15:0] LO_SURR   = 16'hDC00;
    localparam logic [9:0]  SURR_MASK = 10'h3FF;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    typedef logic [QAW-1:0] t_qptr;
    typedef logic [QAW:0]   t_qcnt;

    // one result item
    typedef struct packed {
        logic [15:0] code_unit;
        t_status     status;
        logic        last;
    } t_result;

    // results of one input byte, handed from decoder to queue
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// ===== rtl/u8u16_byte_if.sv =====
// ----------------------------------------------------------------------------
// u8u16_byte_if
// Byte channel: valid, ready and one UTF-8 byte.
// ----------------------------------------------------------------------------
interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

// ===== rtl/u8u16_unit_if.sv =====
// ----------------------------------------------------------------------------
// u8u16_unit_if
// Result channel: valid, ready, one UTF-16 code unit with status and last.
// ----------------------------------------------------------------------------
interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output code_unit, output status, output last,
                    input ready);
    modport sink   (input valid, input code_unit, input status, input last,
                    output ready);
endinterface

// ===== rtl/u8u16_core.sv =====
// ----------------------------------------------------------------------------
// u8u16_core
// Sequence state, strict lead/continuation checks and UTF-16 unit forming.
// ----------------------------------------------------------------------------
module u8u16_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    output u8u16_pkg::t_push  o_push
);

    logic [15:0] r_cap;
    logic [1:0]  r_pending, n_pending;
    logic [20:0] r_acc, n_acc;
    logic [7:0]  r_lo_bnd, n_lo_bnd;
    logic [7:0]  r_hi_bnd, n_hi_bnd;
    logic        r_await, n_await;
    logic [15:0] r_units, n_units;
    logic        r_discard, n_discard;

    logic                 do_fail;
    u8u16_pkg::t_status   fail_st;
    logic                 fail_end;
    logic [20:0]          acc_next;
    logic [20:0]          supp;
    logic [16:0]          units_p2;
    u8u16_pkg::t_push     push;

    assign acc_next = {r_acc[14:0], i_byte[5:0]};
    assign supp     = acc_next - u8u16_pkg::SUPP_BASE;
    assign units_p2 = {1'b0, r_units} + 17'd2;

    // per-byte decode
    always_comb begin
        n_pending = r_pending;
        n_acc     = r_acc;
        n_lo_bnd  = r_lo_bnd;
        n_hi_bnd  = r_hi_bnd;
        n_await   = r_await;
        n_units   = r_units;
        n_discard = r_discard;
        do_fail   = 1'b0;
        fail_st   = u8u16_pkg::ST_BAD;
        fail_end  = 1'b0;
        push      = '0;

        if (i_accept) begin
            if (r_discard) begin
                if (i_byte == 8'd0) begin
                    n_discard = 1'b0;
                    n_pending = 2'd0;
                    n_acc     = '0;
                    n_lo_bnd  = u8u16_pkg::CONT_LO;
                    n_hi_bnd  = u8u16_pkg::CONT_HI;
                    n_await   = 1'b0;
                    n_units   = '0;
                end
            end else if (r_pending == 2'd0) begin
                if (i_byte == 8'd0) begin
                    n_acc     = '0;
                    n_lo_bnd  = u8u16_pkg::CONT_LO;
                    n_hi_bnd  = u8u16_pkg::CONT_HI;
                    n_await   = 1'b0;
                    n_units   = '0;
                    push.cnt  = 2'd1;
                    push.r0   = '{16'd0, u8u16_pkg::ST_TERM, 1'b1};
                end else if (r_units >= r_cap) begin
                    do_fail = 1'b1;
                    fail_st = u8u16_pkg::ST_FULL;
                end else if (i_byte[7] == 1'b0) begin
                    n_units  = r_units + 16'd1;
                    push.cnt = 2'd1;
                    push.r0  = '{{8'd0, i_byte}, u8u16_pkg::ST_DATA, 1'b0};
                end else if (i_byte >= u8u16_pkg::LEAD2_LO
                             && i_byte <= u8u16_pkg::LEAD2_HI) begin
                    n_pending = 2'd1;
                    n_acc     = {16'd0, i_byte[4:0]};
                    n_lo_bnd  = u8u16_pkg::CONT_LO;
                    n_hi_bnd  = u8u16_pkg::CONT_HI;
                    n_await   = 1'b1;
                end else if (i_byte >= u8u16_pkg::LEAD3_LO
                             && i_byte <= u8u16_pkg::LEAD3_HI) begin
                    n_pending = 2'd2;
                    n_acc     = {17'd0, i_byte[3:0]};
                    n_lo_bnd  = (i_byte == u8u16_pkg::LEAD3_LO)
                                ? u8u16_pkg::E0_LO : u8u16_pkg::CONT_LO;
                    n_hi_bnd  = (i_byte == u8u16_pkg::LEAD3_SUR)
                                ? u8u16_pkg::ED_HI : u8u16_pkg::CONT_HI;
                    n_await   = 1'b1;
                end else if (i_byte >= u8u16_pkg::LEAD4_LO
                             && i_byte <= u8u16_pkg::LEAD4_HI) begin
                    n_pending = 2'd3;
                    n_acc     = {18'd0, i_byte[2:0]};
                    n_lo_bnd  = (i_byte == u8u16_pkg::LEAD4_LO)
                                ? u8u16_pkg::F0_LO : u8u16_pkg::CONT_LO;
                    n_hi_bnd  = (i_byte == u8u16_pkg::LEAD4_HI)
                                ? u8u16_pkg::F4_HI : u8u16_pkg::CONT_HI;
                    n_await   = 1'b1;
                end else begin
                    do_fail = 1'b1;
                end
            end else begin
                // continuation byte due
                if (i_byte[7:6] != 2'b10) begin
                    do_fail  = 1'b1;
                    fail_end = (i_byte == 8'd0);
                end else if (r_await && (i_byte < r_lo_bnd || i_byte > r_hi_bnd)) begin
                    do_fail = 1'b1;
                end else begin
                    n_await   = 1'b0;
                    n_acc     = acc_next;
                    n_pending = r_pending - 2'd1;
                    if (r_pending == 2'd1) begin
                        if (acc_next >= u8u16_pkg::SUPP_BASE) begin
                            if (units_p2 > {1'b0, r_cap}) begin
                                do_fail = 1'b1;
                                fail_st = u8u16_pkg::ST_FULL;
                            end else begin
                                push.cnt = 2'd2;
                                push.r0  = '{u8u16_pkg::HI_SURR
                                             | {6'd0, supp[19:10]
                                                & u8u16_pkg::SURR_MASK},
                                             u8u16_pkg::ST_DATA, 1'b0};
                                push.r1  = '{u8u16_pkg::LO_SURR
                                             | {6'd0, supp[9:0]
                                                & u8u16_pkg::SURR_MASK},
                                             u8u16_pkg::ST_DATA, 1'b0};
                                n_units  = units_p2[15:0];
                            end
                        end else begin
                            push.cnt = 2'd1;
                            push.r0  = '{acc_next[15:0], u8u16_pkg::ST_DATA, 1'b0};
                            n_units  = r_units + 16'd1;
                        end
                        n_acc    = '0;
                        n_lo_bnd = u8u16_pkg::CONT_LO;
                        n_hi_bnd = u8u16_pkg::CONT_HI;
                    end
                end
            end

            // error: one result, clear everything, maybe drop to the next zero
            if (do_fail) begin
                n_pending = 2'd0;
                n_acc     = '0;
                n_lo_bnd  = u8u16_pkg::CONT_LO;
                n_hi_bnd  = u8u16_pkg::CONT_HI;
                n_await   = 1'b0;
                n_units   = '0;
                n_discard = !fail_end;
                push.cnt  = 2'd1;
                push.r0   = '{16'd0, fail_st, 1'b1};
                push.r1   = '0;
            end
        end
    end

    assign o_push = push;

    // state and capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= 16'hFFFF;
            r_pending <= 2'd0;
            r_acc     <= '0;
            r_lo_bnd  <= u8u16_pkg::CONT_LO;
            r_hi_bnd  <= u8u16_pkg::CONT_HI;
            r_await   <= 1'b0;
            r_units   <= '0;
            r_discard <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_pending <= n_pending;
            r_acc     <= n_acc;
            r_lo_bnd  <= n_lo_bnd;
            r_hi_bnd  <= n_hi_bnd;
            r_await   <= n_await;
            r_units   <= n_units;
            r_discard <= n_discard;
        end
    end

`ifndef ASSERT_OFF
    // dropping bytes never overlaps an open sequence
    a_discard_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discard |-> (r_pending == 2'd0))
        else $error("discarding with a sequence open");

    // second-byte check only while a sequence is open
    a_await_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> (r_pending != 2'd0))
        else $error("awaiting second byte with no sequence");

    // a surrogate pair is always two data units
    a_pair_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt == 2'd2) |-> (o_push.r0.status == u8u16_pkg::ST_DATA
                                  && o_push.r1.status == u8u16_pkg::ST_DATA
                                  && o_push.r0.code_unit[15:10] == 6'b110110
                                  && o_push.r1.code_unit[15:10] == 6'b110111))
        else $error("malformed surrogate pair");
`endif

endmodule

// ===== rtl/u8u16_fifo.sv =====
// ----------------------------------------------------------------------------
// u8u16_fifo
// Result queue: takes one or two results per cycle, pops one per ready cycle.
// ----------------------------------------------------------------------------
module u8u16_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  u8u16_pkg::t_push   i_push,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output u8u16_pkg::t_result o_result
);

    u8u16_pkg::t_result r_slot [u8u16_pkg::QDEPTH];
    u8u16_pkg::t_qptr   r_wr_ptr, n_wr_ptr;
    u8u16_pkg::t_qptr   r_rd_ptr, n_rd_ptr;
    u8u16_pkg::t_qcnt   r_count, n_count;
    logic               pop;

    // room for the worst case of two results
    assign o_space  = (r_count <= u8u16_pkg::t_qcnt'(u8u16_pkg::QDEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign o_result = r_slot[r_rd_ptr];
    assign pop      = o_valid && i_ready;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr + u8u16_pkg::t_qptr'(i_push.cnt);
        n_rd_ptr = r_rd_ptr + u8u16_pkg::t_qptr'(pop);
        n_count  = r_count + u8u16_pkg::t_qcnt'(i_push.cnt)
                   - u8u16_pkg::t_qcnt'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // slot writes
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_slot[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_slot[r_wr_ptr + u8u16_pkg::t_qptr'(1)] <= i_push.r1;
        end
    end

`ifndef ASSERT_OFF
    // never more results than slots
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= u8u16_pkg::t_qcnt'(u8u16_pkg::QDEPTH))
        else $error("result queue overflow");

    // any push lands only when room was advertised
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_space)
        else $error("push without room");

    // pointer distance tracks the fill count
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[u8u16_pkg::QAW-1:0])
        else $error("queue pointers out of step with fill count");
`endif

endmodule

// ===== rtl/utf8_to_utf16_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Strict UTF-8 to UTF-16 transcoder, one byte in per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte_chan carries one UTF-8 byte per transfer; a zero byte ends the
//   string. o_unit_chan gives UTF-16 code units with a status (data,
//   terminator, invalid sequence, capacity exceeded) and a last flag on the
//   terminator and on every error result.
//   i_cfg_we / i_cfg_wdata load the unit capacity; write it while idle.
// Timing: the results of a byte are registered into the queue together; the
//   low surrogate of a pair sits in the slot right behind the high one.
// Throughput: one byte per cycle. The decoder state updates in a single
//   pass per byte; the four-entry result queue drains one unit per cycle
//   and holds ready low only while fewer than two slots are free.
// Reset: synchronous, active low; clears the sequence state, unit count,
//   discard flag and queue, and sets the capacity to 65535.
// Stall: when the receiver holds ready low the queue fills and byte
//   transfers stop until slots free up; nothing is lost.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    u8u16_byte_if.sink          i_byte_chan,
    u8u16_unit_if.source        o_unit_chan,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata
);

    logic               accept;
    logic               space;
    u8u16_pkg::t_push   push;
    u8u16_pkg::t_result result;

    // input transfer
    assign i_byte_chan.ready = space;
    assign accept            = i_byte_chan.valid && space;

    u8u16_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_byte_chan.byte_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push)
    );

    u8u16_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space  (space),
        .o_valid  (o_unit_chan.valid),
        .i_ready  (o_unit_chan.ready),
        .o_result (result)
    );

    // output payload
    assign o_unit_chan.code_unit = result.code_unit;
    assign o_unit_chan.status    = result.status;
    assign o_unit_chan.last      = result.last;

endmodule
